// ===== rtl/core/lbc_pkg.sv =====
// shared types and constants of the line clipping core
`timescale 1ns / 1ps
package lbc_pkg;

  localparam int NumLanes = 4;

  localparam int WinLeftReset   = 100;
  localparam int WinRightReset  = 500;
  localparam int WinTopReset    = 100;
  localparam int WinBottomReset = 400;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_TOP    = 2'd2,
    REG_BOTTOM = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic rej;
    logic enter;
    logic leave;
    logic over;
  } lane_ctl_t;

endpackage

// ===== rtl/core/lbc_seg_if.sv =====
// input segment channel
`timescale 1ns / 1ps
interface lbc_seg_if #(
  parameter int CB = 12
);
  logic valid;
  logic ready;
  logic signed [CB-1:0] start_x;
  logic signed [CB-1:0] start_y;
  logic signed [CB-1:0] end_x;
  logic signed [CB-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== rtl/core/lbc_clip_if.sv =====
// clipped segment result channel
`timescale 1ns / 1ps
interface lbc_clip_if #(
  parameter int CB = 12
);
  logic valid;
  logic ready;
  logic signed [CB-1:0] clipped_start_x;
  logic signed [CB-1:0] clipped_start_y;
  logic signed [CB-1:0] clipped_end_x;
  logic signed [CB-1:0] clipped_end_y;
  logic visible;
  logic was_changed;

  modport source (output valid, clipped_start_x, clipped_start_y, clipped_end_x,
                  clipped_end_y, visible, was_changed, input ready);
  modport sink (input valid, clipped_start_x, clipped_start_y, clipped_end_x,
                clipped_end_y, visible, was_changed, output ready);
endinterface

// ===== rtl/core/lbc_setup.sv =====
// first stage: edge terms p and q, magnitudes and lane classification
`timescale 1ns / 1ps
module lbc_setup #(
  parameter int CB = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [CB-1:0]        x0,
  input  logic signed [CB-1:0]        y0,
  input  logic signed [CB-1:0]        x1,
  input  logic signed [CB-1:0]        y1,
  input  logic signed [CB-1:0]        win_left,
  input  logic signed [CB-1:0]        win_right,
  input  logic signed [CB-1:0]        win_top,
  input  logic signed [CB-1:0]        win_bottom,
  output logic                        valid_r,
  output logic signed [CB-1:0]        x0_r,
  output logic signed [CB-1:0]        y0_r,
  output logic signed [CB-1:0]        x1_r,
  output logic signed [CB-1:0]        y1_r,
  output logic signed [CB:0]          dx_r,
  output logic signed [CB:0]          dy_r,
  output logic [lbc_pkg::NumLanes-1:0][CB:0] num_r,
  output logic [lbc_pkg::NumLanes-1:0][CB:0] den_r,
  output lbc_pkg::lane_ctl_t [lbc_pkg::NumLanes-1:0] ctl_r
);
  import lbc_pkg::*;

  logic signed [CB:0] dx_w;
  logic signed [CB:0] dy_w;
  logic signed [CB:0] p_w [NumLanes];
  logic signed [CB:0] q_w [NumLanes];
  logic [NumLanes-1:0][CB:0] num_nxt;
  logic [NumLanes-1:0][CB:0] den_nxt;
  lane_ctl_t [NumLanes-1:0] ctl_nxt;

  assign dx_w = (CB+1)'(x1) - (CB+1)'(x0);
  assign dy_w = (CB+1)'(y1) - (CB+1)'(y0);

  always_comb begin
    p_w[0] = -dx_w;
    p_w[1] = dx_w;
    p_w[2] = -dy_w;
    p_w[3] = dy_w;
    q_w[0] = (CB+1)'(x0) - (CB+1)'(win_left);
    q_w[1] = (CB+1)'(win_right) - (CB+1)'(x0);
    q_w[2] = (CB+1)'(y0) - (CB+1)'(win_top);
    q_w[3] = (CB+1)'(win_bottom) - (CB+1)'(y0);
    for (int i = 0; i < NumLanes; i++) begin
      num_nxt[i] = q_w[i][CB] ? (CB+1)'(-q_w[i]) : (CB+1)'(q_w[i]);
      den_nxt[i] = p_w[i][CB] ? (CB+1)'(-p_w[i]) : (CB+1)'(p_w[i]);
      ctl_nxt[i].rej   = q_w[i][CB] && !p_w[i][CB];
      ctl_nxt[i].enter = p_w[i][CB] && q_w[i][CB];
      ctl_nxt[i].leave = !p_w[i][CB] && (p_w[i] != '0) && !q_w[i][CB];
      ctl_nxt[i].over  = num_nxt[i] >= den_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= x0;
      y0_r  <= y0;
      x1_r  <= x1;
      y1_r  <= y1;
      dx_r  <= dx_w;
      dy_r  <= dy_w;
      num_r <= num_nxt;
      den_r <= den_nxt;
      ctl_r <= ctl_nxt;
    end
  end
endmodule

// ===== rtl/core/lbc_divider.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module lbc_divider #(
  parameter int CB = 12,
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [CB:0]   num,
  input  logic [CB:0]   den,
  output logic [FB-1:0] quo
);
  logic [CB:0]   rem_r [FB];
  logic [CB:0]   den_r [FB];
  logic [FB-1:0] quo_r [FB];

  for (genvar k = 0; k < FB; k++) begin : g_stage
    logic [CB:0]   rem_in;
    logic [CB:0]   den_in;
    logic [FB-1:0] quo_in;
    logic [CB+1:0] sh;
    logic          ge;
    logic [CB+1:0] diff;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign sh   = {rem_in, 1'b0};
    assign ge   = sh >= {1'b0, den_in};
    assign diff = sh - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[CB:0] : sh[CB:0];
        den_r[k] <= den_in;
        quo_r[k] <= {quo_in[FB-2:0], ge};
      end
    end
  end

  assign quo = quo_r[FB-1];
endmodule

// ===== rtl/core/lbc_finish.sv =====
// interval update, endpoint scaling and result register
`timescale 1ns / 1ps
module lbc_finish #(
  parameter int CB = 12,
  parameter int FB = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [CB-1:0]        x0,
  input  logic signed [CB-1:0]        y0,
  input  logic signed [CB-1:0]        x1,
  input  logic signed [CB-1:0]        y1,
  input  logic signed [CB:0]          dx,
  input  logic signed [CB:0]          dy,
  input  lbc_pkg::lane_ctl_t [lbc_pkg::NumLanes-1:0] ctl,
  input  logic [lbc_pkg::NumLanes-1:0][FB-1:0] quo,
  lbc_clip_if.source                  out_if
);
  import lbc_pkg::*;

  localparam int TW = FB + 1;
  localparam int PW = TW + CB + 1;
  localparam int SW = CB + 3;

  // interval stage
  logic [TW-1:0] r_w [NumLanes];
  logic [TW-1:0] t1_w;
  logic [TW-1:0] t2_w;
  logic          rej_w;

  logic                 v1_r;
  logic [TW-1:0]        t1_r;
  logic [TW-1:0]        t2_r;
  logic                 rej1_r;
  logic signed [CB-1:0] x0_1_r, y0_1_r, x1_1_r, y1_1_r;
  logic signed [CB:0]   dx_1_r, dy_1_r;

  always_comb begin
    t1_w  = '0;
    t2_w  = {1'b1, {FB{1'b0}}};
    rej_w = 1'b0;
    for (int i = 0; i < NumLanes; i++) begin
      r_w[i] = ctl[i].over ? {1'b1, {FB{1'b0}}} : {1'b0, quo[i]};
      if (ctl[i].rej) begin
        rej_w = 1'b1;
      end
      if (ctl[i].enter && (r_w[i] > t1_w)) begin
        t1_w = r_w[i];
      end
      if (ctl[i].leave && (r_w[i] < t2_w)) begin
        t2_w = r_w[i];
      end
    end
    if (t1_w >= t2_w) begin
      rej_w = 1'b1;
    end
  end

  // scaling stage
  logic [CB:0]   adx_w, ady_w;
  logic          v2_r;
  logic          rej2_r;
  logic          sx_r, sy_r;
  logic [PW-1:0] psx_r, psy_r, pex_r, pey_r;
  logic signed [CB-1:0] x0_2_r, y0_2_r, x1_2_r, y1_2_r;

  assign adx_w = dx_1_r[CB] ? (CB+1)'(-dx_1_r) : (CB+1)'(dx_1_r);
  assign ady_w = dy_1_r[CB] ? (CB+1)'(-dy_1_r) : (CB+1)'(dy_1_r);

  // endpoint stage
  logic [SW-1:0] msx_w, msy_w, mex_w, mey_w;
  logic signed [SW-1:0] csx_w, csy_w, cex_w, cey_w;
  logic signed [SW-1:0] x0e_w, y0e_w, x1e_w, y1e_w;
  logic          chg_w;

  assign msx_w = SW'(psx_r[PW-1:FB]);
  assign msy_w = SW'(psy_r[PW-1:FB]);
  assign mex_w = SW'(pex_r[PW-1:FB]);
  assign mey_w = SW'(pey_r[PW-1:FB]);
  assign x0e_w = SW'(x0_2_r);
  assign y0e_w = SW'(y0_2_r);
  assign x1e_w = SW'(x1_2_r);
  assign y1e_w = SW'(y1_2_r);
  assign csx_w = x0e_w + (sx_r ? -$signed(msx_w) : $signed(msx_w));
  assign csy_w = y0e_w + (sy_r ? -$signed(msy_w) : $signed(msy_w));
  assign cex_w = x0e_w + (sx_r ? -$signed(mex_w) : $signed(mex_w));
  assign cey_w = y0e_w + (sy_r ? -$signed(mey_w) : $signed(mey_w));
  assign chg_w = (csx_w != x0e_w) || (csy_w != y0e_w) ||
                 (cex_w != x1e_w) || (cey_w != y1e_w);

  logic out_valid_r;
  logic signed [CB-1:0] osx_r, osy_r, oex_r, oey_r;
  logic vis_r, chg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= t1_w;
      t2_r   <= t2_w;
      rej1_r <= rej_w;
      x0_1_r <= x0;
      y0_1_r <= y0;
      x1_1_r <= x1;
      y1_1_r <= y1;
      dx_1_r <= dx;
      dy_1_r <= dy;

      rej2_r <= rej1_r;
      sx_r   <= dx_1_r[CB];
      sy_r   <= dy_1_r[CB];
      psx_r  <= PW'(t1_r) * PW'(adx_w);
      psy_r  <= PW'(t1_r) * PW'(ady_w);
      pex_r  <= PW'(t2_r) * PW'(adx_w);
      pey_r  <= PW'(t2_r) * PW'(ady_w);
      x0_2_r <= x0_1_r;
      y0_2_r <= y0_1_r;
      x1_2_r <= x1_1_r;
      y1_2_r <= y1_1_r;

      osx_r <= rej2_r ? '0 : csx_w[CB-1:0];
      osy_r <= rej2_r ? '0 : csy_w[CB-1:0];
      oex_r <= rej2_r ? '0 : cex_w[CB-1:0];
      oey_r <= rej2_r ? '0 : cey_w[CB-1:0];
      vis_r <= !rej2_r;
      chg_r <= !rej2_r && chg_w;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.clipped_start_x = osx_r;
  assign out_if.clipped_start_y = osy_r;
  assign out_if.clipped_end_x   = oex_r;
  assign out_if.clipped_end_y   = oey_r;
  assign out_if.visible         = vis_r;
  assign out_if.was_changed     = chg_r;
endmodule

// ===== rtl/core/liang_barsky_line_clip_core.sv =====
// top level of the line clipping core
`timescale 1ns / 1ps
// clips line segments against a rectangular window with the liang-barsky
// parametric method
// in_if carries one segment per transaction (start and end point, signed);
// out_if returns one transaction per segment: clipped endpoints, visible and
// was_changed; rejected segments come back with zero endpoints
// the window sits in four registers written through cfg_we, cfg_index and
// cfg_data (left, right, top, bottom); write them only while the core is idle
// the pipeline has one setup stage, one divider stage per quotient bit, then
// interval, multiply and result stages; a new segment is taken every cycle
// unless the output stalls
// when out_if.ready is low with a result waiting, the whole pipeline holds
// and in_if.ready drops, nothing is lost or repeated
// reset clears all valid bits and loads the default window 100..500 by
// 100..400
module liang_barsky_line_clip_core #(
  parameter int COORD_BITS    = 12,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lbc_seg_if.sink               in_if,
  lbc_clip_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);
  import lbc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int FB = FRACTION_BITS;

  logic en;
  logic signed [CB-1:0] win_left_r, win_right_r, win_top_r, win_bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= CB'(WinLeftReset);
      win_right_r  <= CB'(WinRightReset);
      win_top_r    <= CB'(WinTopReset);
      win_bottom_r <= CB'(WinBottomReset);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEFT:   win_left_r   <= cfg_data;
        REG_RIGHT:  win_right_r  <= cfg_data;
        REG_TOP:    win_top_r    <= cfg_data;
        REG_BOTTOM: win_bottom_r <= cfg_data;
        default:    win_left_r   <= win_left_r;
      endcase
    end
  end

  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  logic                 s_valid;
  logic signed [CB-1:0] s_x0, s_y0, s_x1, s_y1;
  logic signed [CB:0]   s_dx, s_dy;
  logic [NumLanes-1:0][CB:0] s_num, s_den;
  lane_ctl_t [NumLanes-1:0]  s_ctl;

  lbc_setup #(.CB(CB)) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_if.valid),
    .x0        (in_if.start_x),
    .y0        (in_if.start_y),
    .x1        (in_if.end_x),
    .y1        (in_if.end_y),
    .win_left  (win_left_r),
    .win_right (win_right_r),
    .win_top   (win_top_r),
    .win_bottom(win_bottom_r),
    .valid_r   (s_valid),
    .x0_r      (s_x0),
    .y0_r      (s_y0),
    .x1_r      (s_x1),
    .y1_r      (s_y1),
    .dx_r      (s_dx),
    .dy_r      (s_dy),
    .num_r     (s_num),
    .den_r     (s_den),
    .ctl_r     (s_ctl)
  );

  logic [NumLanes-1:0][FB-1:0] d_quo;

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    lbc_divider #(.CB(CB), .FB(FB)) u_div (
      .clk(clk),
      .en (en),
      .num(s_num[i]),
      .den(s_den[i]),
      .quo(d_quo[i])
    );
  end

  // side data delayed alongside the divider stages
  logic                 dl_valid_r [FB];
  logic signed [CB-1:0] dl_x0_r [FB];
  logic signed [CB-1:0] dl_y0_r [FB];
  logic signed [CB-1:0] dl_x1_r [FB];
  logic signed [CB-1:0] dl_y1_r [FB];
  logic signed [CB:0]   dl_dx_r [FB];
  logic signed [CB:0]   dl_dy_r [FB];
  lane_ctl_t [NumLanes-1:0] dl_ctl_r [FB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FB; k++) begin
        dl_valid_r[k] <= 1'b0;
      end
    end else if (en) begin
      dl_valid_r[0] <= s_valid;
      for (int k = 1; k < FB; k++) begin
        dl_valid_r[k] <= dl_valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_x0_r[0]  <= s_x0;
      dl_y0_r[0]  <= s_y0;
      dl_x1_r[0]  <= s_x1;
      dl_y1_r[0]  <= s_y1;
      dl_dx_r[0]  <= s_dx;
      dl_dy_r[0]  <= s_dy;
      dl_ctl_r[0] <= s_ctl;
      for (int k = 1; k < FB; k++) begin
        dl_x0_r[k]  <= dl_x0_r[k-1];
        dl_y0_r[k]  <= dl_y0_r[k-1];
        dl_x1_r[k]  <= dl_x1_r[k-1];
        dl_y1_r[k]  <= dl_y1_r[k-1];
        dl_dx_r[k]  <= dl_dx_r[k-1];
        dl_dy_r[k]  <= dl_dy_r[k-1];
        dl_ctl_r[k] <= dl_ctl_r[k-1];
      end
    end
  end

  lbc_finish #(.CB(CB), .FB(FB)) u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(dl_valid_r[FB-1]),
    .x0      (dl_x0_r[FB-1]),
    .y0      (dl_y0_r[FB-1]),
    .x1      (dl_x1_r[FB-1]),
    .y1      (dl_y1_r[FB-1]),
    .dx      (dl_dx_r[FB-1]),
    .dy      (dl_dy_r[FB-1]),
    .ctl     (dl_ctl_r[FB-1]),
    .quo     (d_quo),
    .out_if  (out_if)
  );
endmodule
